/* rtl/u7d_pkg.sv */
// Shared types, character codes and the modified Base64 alphabet decode.
`timescale 1ns / 1ps

package u7d_pkg;

    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned MAX_BYTES = 3;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [1:0]                count;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [SEXTET_W:0] sextet_decode(input logic [7:0] ch);
        logic [SEXTET_W:0] res;
        res = '0;
        case (ch) inside
            [8'h41:8'h5A]: res = {1'b1, SEXTET_W'(ch - 8'h41)};
            [8'h61:8'h7A]: res = {1'b1, SEXTET_W'(ch - 8'd71)};
            [8'h30:8'h39]: res = {1'b1, SEXTET_W'(ch + 8'd4)};
            8'h2B:         res = {1'b1, SEXTET_W'(62)};
            8'h2F:         res = {1'b1, SEXTET_W'(63)};
            default:       res = '0;
        endcase
        return res;
    endfunction

endpackage

/* rtl/u7d_front.sv */
// Front end: accepts input bytes, tracks the base64 run and builds output bundles.
`timescale 1ns / 1ps

module u7d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_in_byte,
    input  logic             i_end_of_input,
    input  u7d_pkg::t_q_status i_q_status,
    output logic             o_stall,
    output logic             o_push,
    output u7d_pkg::t_bundle o_bundle
);
    import u7d_pkg::*;

    logic        r_in_base64, n_in_base64;
    logic        r_just_entered, n_just_entered;
    logic [1:0]  r_sextet_count, n_sextet_count;
    logic [17:0] r_group_bits, n_group_bits;

    logic              accept;
    logic [SEXTET_W:0] dec;
    logic [23:0]       full_group;
    t_bundle           bundle;
    t_bundle           partial;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    assign dec     = sextet_decode(i_in_byte);
    assign full_group = {r_group_bits, dec[SEXTET_W-1:0]};

    always_comb begin
        partial = '0;
        case (r_sextet_count)
            2'd2: begin
                partial.bytes[0] = r_group_bits[11:4];
                partial.count    = 2'd1;
            end
            2'd3: begin
                partial.bytes[0] = r_group_bits[17:10];
                partial.bytes[1] = r_group_bits[9:2];
                partial.count    = 2'd2;
            end
            default: partial = '0;
        endcase
    end

    always_comb begin
        bundle         = '0;
        n_in_base64    = r_in_base64;
        n_just_entered = r_just_entered;
        n_sextet_count = r_sextet_count;
        n_group_bits   = r_group_bits;
        if (i_end_of_input) begin
            if (r_in_base64) begin
                if (r_just_entered) begin
                    bundle.bytes[0] = C_PLUS;
                    bundle.count    = 2'd1;
                end else begin
                    bundle = partial;
                end
            end
            n_in_base64    = 1'b0;
            n_just_entered = 1'b0;
            n_sextet_count = '0;
            n_group_bits   = '0;
        end else if (!r_in_base64) begin
            if (i_in_byte == C_PLUS) begin
                n_in_base64    = 1'b1;
                n_just_entered = 1'b1;
                n_sextet_count = '0;
                n_group_bits   = '0;
            end else begin
                bundle.bytes[0] = i_in_byte;
                bundle.count    = 2'd1;
            end
        end else if (dec[SEXTET_W]) begin
            n_just_entered = 1'b0;
            if (r_sextet_count == 2'd3) begin
                bundle.bytes[0] = full_group[23:16];
                bundle.bytes[1] = full_group[15:8];
                bundle.bytes[2] = full_group[7:0];
                bundle.count    = 2'd3;
                n_sextet_count  = '0;
                n_group_bits    = '0;
            end else begin
                n_group_bits   = full_group[17:0];
                n_sextet_count = r_sextet_count + 2'd1;
            end
        end else begin
            if (r_just_entered && i_in_byte == C_MINUS) begin
                bundle.bytes[0] = C_PLUS;
                bundle.count    = 2'd1;
            end else begin
                bundle = partial;
                if (i_in_byte != C_MINUS) begin
                    bundle.bytes[partial.count] = i_in_byte;
                    bundle.count = partial.count + 2'd1;
                end
            end
            n_in_base64    = 1'b0;
            n_just_entered = 1'b0;
            n_sextet_count = '0;
            n_group_bits   = '0;
        end
    end

    assign o_push   = accept && (bundle.count != 2'd0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_base64    <= 1'b0;
            r_just_entered <= 1'b0;
            r_sextet_count <= '0;
            r_group_bits   <= '0;
        end else if (accept) begin
            r_in_base64    <= n_in_base64;
            r_just_entered <= n_just_entered;
            r_sextet_count <= n_sextet_count;
            r_group_bits   <= n_group_bits;
        end
    end

endmodule

/* rtl/u7d_queue.sv */
// Bundle queue between the front end and the output serializer.
`timescale 1ns / 1ps

module u7d_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u7d_pkg::t_bundle   i_bundle,
    input  logic               i_pop,
    output u7d_pkg::t_bundle   o_head,
    output u7d_pkg::t_q_status o_status
);
    import u7d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/u7d_back.sv */
// Back end: serializes queued bundles into the registered output byte stream.
`timescale 1ns / 1ps

module u7d_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  u7d_pkg::t_bundle   i_head,
    input  u7d_pkg::t_q_status i_q_status,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);
    import u7d_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic       load;
    logic       take;
    logic       is_last;
    logic [7:0] sel_byte;

    assign load    = !r_valid || !i_stall;
    assign take    = load && !i_q_status.empty;
    assign is_last = (r_idx == i_head.count - 2'd1);
    assign o_pop   = take && is_last;
    assign n_idx   = o_pop ? 2'd0 : r_idx + 2'd1;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.bytes[0];
            2'd1:    sel_byte = i_head.bytes[1];
            2'd2:    sel_byte = i_head.bytes[2];
            default: sel_byte = i_head.bytes[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_q_status.empty;
            end
            if (take) begin
                r_idx <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= sel_byte;
            r_last <= is_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

endmodule

/* rtl/utf7_modified_base64_decoder.sv */
// Path: an accepted byte is decoded into a bundle, held in the bundle queue, then registered at the output.
// Throughput: one input byte per cycle while o_stall is low; the output moves one byte
// per cycle while i_stall is low; the serializer sends an item's k bytes in turn.
// The bundle queue (QUEUE_DEPTH entries) absorbs three-byte bursts before input stalls.
// Reset: synchronous active-low; direct mode, queue empty, no output pending.
`timescale 1ns / 1ps

module utf7_modified_base64_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import u7d_pkg::*;

    logic      push;
    logic      pop;
    t_bundle   push_bundle;
    t_bundle   head;
    t_q_status q_status;

    u7d_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_q_status     (q_status),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_bundle       (push_bundle)
    );

    u7d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    u7d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_bundle_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (push_bundle.count != 2'd0))
        else $error("empty bundle pushed");

    a_status_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

endmodule

/* tb/utf7_modified_base64_decoder_tb.sv */
// Self-checking testbench for the streaming modified Base64 (UTF-7 style) decoder.
`timescale 1ns / 1ps

module utf7_modified_base64_decoder_tb;

    import u7d_pkg::C_PLUS;
    import u7d_pkg::C_MINUS;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 430;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_decoded;

    class decoded_byte_scoreboard;
        bit         in_run;
        bit         fresh_plus;
        bit [1:0]   sextets_held;
        bit [17:0]  held_bits;
        logic [7:0] burst[$];
        t_decoded   awaited[$];
        int         errors;

        function bit [6:0] sextet_of(logic [7:0] ch);
            if (ch >= "A" && ch <= "Z") return {1'b1, 6'(ch - "A")};
            if (ch >= "a" && ch <= "z") return {1'b1, 6'(ch - "a" + 26)};
            if (ch >= "0" && ch <= "9") return {1'b1, 6'(ch - "0" + 52)};
            if (ch == C_PLUS) return {1'b1, 6'd62};
            if (ch == "/") return {1'b1, 6'd63};
            return 7'd0;
        endfunction

        function void leave_run();
            in_run = 1'b0;
            fresh_plus = 1'b0;
            sextets_held = 2'd0;
            held_bits = 18'd0;
        endfunction

        function void flush_group();
            if (sextets_held == 2'd2) begin
                burst.push_back(held_bits[11:4]);
            end else if (sextets_held == 2'd3) begin
                burst.push_back(held_bits[17:10]);
                burst.push_back(held_bits[9:2]);
            end
        endfunction

        function void note_input(logic [7:0] b, logic eoi);
            bit [6:0]  sx;
            bit [23:0] full;
            t_decoded  e;
            burst.delete();
            sx = sextet_of(b);
            if (eoi) begin
                if (in_run) begin
                    if (fresh_plus) burst.push_back(C_PLUS);
                    else flush_group();
                end
                leave_run();
            end else if (!in_run) begin
                if (b == C_PLUS) begin
                    in_run = 1'b1;
                    fresh_plus = 1'b1;
                    sextets_held = 2'd0;
                    held_bits = 18'd0;
                end else begin
                    burst.push_back(b);
                end
            end else if (sx[6]) begin
                fresh_plus = 1'b0;
                if (sextets_held == 2'd3) begin
                    full = {held_bits, sx[5:0]};
                    burst.push_back(full[23:16]);
                    burst.push_back(full[15:8]);
                    burst.push_back(full[7:0]);
                    sextets_held = 2'd0;
                    held_bits = 18'd0;
                end else begin
                    held_bits = {held_bits[11:0], sx[5:0]};
                    sextets_held = sextets_held + 2'd1;
                end
            end else begin
                if (fresh_plus && b == C_MINUS) begin
                    burst.push_back(C_PLUS);
                end else begin
                    flush_group();
                    if (b != C_MINUS) burst.push_back(b);
                end
                leave_run();
            end
            foreach (burst[i]) begin
                e.data = burst[i];
                e.last = (i == burst.size() - 1);
                awaited.push_back(e);
            end
        endfunction

        function void check_output(logic [7:0] b, logic last);
            t_decoded e;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected output byte %02h last %0d", b, last);
                return;
            end
            e = awaited.pop_front();
            if (e.data !== b || e.last !== last) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: expected byte %02h last %0d, got byte %02h last %0d",
                             e.data, e.last, b, last);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_input = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last;

    decoded_byte_scoreboard sb;
    bit quiet = 1'b0;
    int sent_items = 0;
    int stall_hold = 0;
    int cycles = 0;

    utf7_modified_base64_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] base64_char(int v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return C_PLUS;
        return 8'("/");
    endfunction

    function automatic logic [7:0] run_breaker();
        logic [7:0] c;
        bit [6:0]   sx;
        do begin
            c = 8'($urandom);
            sx = sb.sextet_of(c);
        end while (sx[6] || c == C_MINUS);
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        gap = quiet ? 0 : idle_cycles();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_end_of_input <= eoi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_byte(8'($urandom), 1'b1);
    endtask

    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 2) == 0);
            stall_hold <= idle_cycles();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_input(i_in_byte, i_end_of_input);
            if (o_valid && !i_stall) sb.check_output(o_out_byte, o_last);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int kind;
        int tail;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("A");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("+-");
        send_text("+AAAA///.");
        send_text("+//");
        send_end();
        send_text("+z-");
        send_text("+!");
        send_byte(C_PLUS, 1'b0);
        send_end();
        send_end();

        while (sent_items < RANDOM_ITEMS) begin
            quiet <= ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                send_byte(C_PLUS, 1'b0);
                repeat ($urandom_range(0, 10)) send_byte(base64_char($urandom_range(0, 63)), 1'b0);
                tail = $urandom_range(0, 3);
                if (tail < 2) send_byte(C_MINUS, 1'b0);
                else if (tail == 2) send_byte(run_breaker(), 1'b0);
                else send_end();
            end else if (kind < 65) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(32, 126)), 1'b0);
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end else if (kind < 87) begin
                send_end();
            end else if (kind < 94) begin
                send_text("+-");
            end else begin
                send_byte(C_PLUS, 1'b0);
                send_end();
            end
        end

        i_valid <= 1'b0;
        quiet <= 1'b1;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/u7d_pkg.sv
rtl/u7d_front.sv
rtl/u7d_queue.sv
rtl/u7d_back.sv
rtl/utf7_modified_base64_decoder.sv
tb/utf7_modified_base64_decoder_tb.sv
